[hdl/sdrrip_pkg.sv]
// Shared constants for the SHiP/DRRIP stream-aware replacement block.
// No dependencies.
package sdrrip_pkg;
    localparam int NUM_SETS     = 2048;
    localparam int NUM_WAYS     = 16;
    localparam int SIG_ENTRIES  = 64;
    localparam int LEADER_COUNT = 32;
    localparam int SET_W        = $clog2(NUM_SETS);
    localparam int WAY_W        = $clog2(NUM_WAYS);
    localparam int SIG_W        = 6;
    localparam int SPACING      = NUM_SETS / LEADER_COUNT;
    localparam logic [9:0] SEL_MID = 10'd512;
    localparam logic [9:0] SEL_MAX = 10'd1023;
    localparam logic [1:0] AGE_MAX = 2'd3;
    localparam logic [1:0] AGE_INIT = 2'd2;
    localparam logic [1:0] CNT_HOT = 2'd2;
    localparam logic [1:0] CNT_INIT = 2'd1;

    localparam logic KIND_QUERY  = 1'b0;
    localparam logic KIND_UPDATE = 1'b1;

    localparam logic [1:0] LK_FOLLOW = 2'd0;
    localparam logic [1:0] LK_SRRIP  = 2'd1;
    localparam logic [1:0] LK_BRRIP  = 2'd2;

    function automatic logic [1:0] leader_kind(input logic [SET_W-1:0] s);
        int idx;
        idx = int'(s) / SPACING;
        if ((int'(s) % SPACING) != 0 || idx >= LEADER_COUNT) return LK_FOLLOW;
        return (idx < LEADER_COUNT / 2) ? LK_SRRIP : LK_BRRIP;
    endfunction
endpackage

[hdl/ship_drrip_stream_replacement.sv]
// SHiP-lite + DRRIP replacement with per-set stride streaming; depends on sdrrip_pkg.
// Query: a max pass over the ways, then an age pass that ages the set and picks the victim.
// Update: per-set reads, then signature counter read-modify-writes, then the result.
// One beat in flight: s_ready returns the cycle after the result beat is taken, so a new
//   beat is not accepted until the previous result has been taken.
// Reset: a clearing pass over all NUM_SETS*NUM_WAYS age entries fills all RAMs; s_ready stays low.
module ship_drrip_stream_replacement (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_kind,
    input  logic [10:0] s_set_index,
    input  logic [3:0]  s_way,
    input  logic [63:0] s_pc,
    input  logic [47:0] s_address,
    input  logic        s_hit,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_victim_way,
    output logic [1:0]  m_inserted_age,
    output logic        m_streaming
);
    localparam int SW = sdrrip_pkg::SET_W;
    localparam int WW = sdrrip_pkg::WAY_W;
    localparam int AW = SW + WW;

    localparam logic [3:0] ST_CLR  = 4'd0;
    localparam logic [3:0] ST_IDLE = 4'd1;
    localparam logic [3:0] ST_QRD  = 4'd2;
    localparam logic [3:0] ST_QMAX = 4'd3;
    localparam logic [3:0] ST_QAGE = 4'd4;
    localparam logic [3:0] ST_URD  = 4'd5;
    localparam logic [3:0] ST_UOLD = 4'd6;
    localparam logic [3:0] ST_UNEW = 4'd7;
    localparam logic [3:0] ST_UWR  = 4'd8;
    localparam logic [3:0] ST_OUT  = 4'd9;
    localparam logic [3:0] ST_QEND = 4'd10;
    localparam logic [3:0] ST_UDEC = 4'd11;
    localparam logic [3:0] ST_URDN = 4'd12;

    // memories
    logic [1:0]  age_mem [0:(1<<AW)-1];
    logic [5:0]  sig_mem [0:(1<<AW)-1];
    logic [47:0] paddr_mem [0:(1<<SW)-1];
    logic [48:0] pstr_mem [0:(1<<SW)-1];
    logic [1:0]  scnt_mem [0:(1<<SW)-1];
    logic [1:0]  sigcnt_mem [0:sdrrip_pkg::SIG_ENTRIES-1];

    logic [3:0]    state_reg;
    logic [AW-1:0] clr_reg;
    logic [WW:0]   cnt_reg;
    logic [SW-1:0] set_reg;
    logic [WW-1:0] way_reg;
    logic [5:0]    sig_reg;
    logic [47:0]   addr_reg;
    logic          hit_reg;
    logic [9:0]    sel_reg;
    logic [1:0]    age_rd_reg, scnt_rd_reg, delta_reg;
    logic [5:0]    sig_rd_reg;
    logic [47:0]   pa_rd_reg;
    logic [48:0]   ps_rd_reg;
    logic [1:0]    sigc_rd_reg;
    logic [WW-1:0] rd_idx_reg;
    logic          rd_vld_reg;
    logic [1:0]    age_out_reg;
    logic          strm_reg;
    logic [WW-1:0] vic_out_reg;

    logic          age_we, sig_we, set_we;
    logic [AW-1:0] age_wa, age_ra;
    logic [1:0]    age_wd;
    logic [5:0]    sig_wd;
    logic [47:0]   pa_wd;
    logic [48:0]   ps_wd;
    logic [1:0]    sc_wd;
    logic          sigc_we;
    logic [5:0]    sigc_wa, sigc_ra;
    logic [1:0]    sigc_wd;

    logic [1:0] max_age;
    logic [WW-1:0] victim;
    logic found;
    logic scan_start;
    logic scan_pass2;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);
    assign m_victim_way   = vic_out_reg;
    assign m_inserted_age = age_out_reg;
    assign m_streaming    = strm_reg;

    assign scan_start = (state_reg == ST_QRD);
    // the first age-pass cycle only loads delta_reg; hold the victim search until it is valid
    assign scan_pass2 = (state_reg == ST_QAGE && rd_vld_reg) || (state_reg == ST_QEND);

    sdrrip_age_scan u_scan (
        .aclk(aclk), .start(scan_start), .pass2(scan_pass2),
        .idx(rd_idx_reg), .age(age_rd_reg + (scan_pass2 ? delta_reg : 2'd0)),
        .max_age(max_age), .victim(victim), .found(found)
    );

    // stride and streaming update, computed from the registered per-set reads
    logic [48:0] stride;
    logic        match;
    logic [1:0]  scnt_upd;
    logic [1:0]  lk;
    logic        brrip_sel;
    always_comb begin
        stride = (pa_rd_reg != 48'd0) ? ({1'b0, addr_reg} - {1'b0, pa_rd_reg}) : 49'd0;
        match  = (pa_rd_reg != 48'd0) && (stride == ps_rd_reg);
        if (match) scnt_upd = (scnt_rd_reg < 2'd3) ? scnt_rd_reg + 2'd1 : scnt_rd_reg;
        else       scnt_upd = (scnt_rd_reg > 2'd0) ? scnt_rd_reg - 2'd1 : scnt_rd_reg;
        lk = sdrrip_pkg::leader_kind(set_reg);
        case (lk)
            sdrrip_pkg::LK_SRRIP: brrip_sel = 1'b0;
            sdrrip_pkg::LK_BRRIP: brrip_sel = 1'b1;
            default:              brrip_sel = (sel_reg >= sdrrip_pkg::SEL_MID);
        endcase
    end

    // signature counter read: old signature first, then the access's own signature
    assign sigc_ra = (state_reg == ST_UOLD) ? sig_rd_reg : sig_reg;

    // RAM write control
    always_comb begin
        age_we = 1'b0; sig_we = 1'b0; set_we = 1'b0; sigc_we = 1'b0;
        age_wa = {set_reg, way_reg}; age_wd = age_out_reg; sig_wd = sig_reg;
        pa_wd = addr_reg; ps_wd = stride; sc_wd = scnt_upd;
        age_ra = {set_reg, cnt_reg[WW-1:0]};
        sigc_wa = sig_rd_reg;
        // reward on a hit, decay on a miss, both saturating
        if (hit_reg) sigc_wd = (sigc_rd_reg < 2'd3) ? sigc_rd_reg + 2'd1 : sigc_rd_reg;
        else         sigc_wd = (sigc_rd_reg > 2'd0) ? sigc_rd_reg - 2'd1 : sigc_rd_reg;
        case (state_reg)
            ST_CLR: begin
                age_we = 1'b1; sig_we = 1'b1; set_we = (clr_reg[AW-1:SW] == '0);
                age_wa = clr_reg[AW-1:0]; age_wd = sdrrip_pkg::AGE_INIT; sig_wd = 6'd0;
                pa_wd = 48'd0; ps_wd = 49'd0; sc_wd = 2'd0;
                sigc_we = 1'b1; sigc_wa = clr_reg[5:0]; sigc_wd = sdrrip_pkg::CNT_INIT;
            end
            ST_QAGE: begin
                age_we = rd_vld_reg;
                age_wa = {set_reg, rd_idx_reg};
                age_wd = age_rd_reg + delta_reg;
            end
            ST_QEND: begin
                age_we = 1'b1;
                age_wa = {set_reg, rd_idx_reg};
                age_wd = age_rd_reg + delta_reg;
            end
            ST_UWR: begin
                age_we = 1'b1; sig_we = !hit_reg;
            end
            ST_UOLD: set_we = 1'b1;
            ST_UDEC: sigc_we = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (age_we) age_mem[age_wa] <= age_wd;
        if (sig_we) sig_mem[age_wa] <= sig_wd;
        if (set_we) begin
            paddr_mem[state_reg == ST_CLR ? clr_reg[SW-1:0] : set_reg] <= pa_wd;
            pstr_mem[state_reg == ST_CLR ? clr_reg[SW-1:0] : set_reg]  <= ps_wd;
            scnt_mem[state_reg == ST_CLR ? clr_reg[SW-1:0] : set_reg]  <= sc_wd;
        end
        if (sigc_we) sigcnt_mem[sigc_wa] <= sigc_wd;
        age_rd_reg <= age_mem[age_ra];
        rd_idx_reg <= cnt_reg[WW-1:0];
        sig_rd_reg <= sig_mem[{set_reg, way_reg}];
        pa_rd_reg  <= paddr_mem[set_reg];
        ps_rd_reg  <= pstr_mem[set_reg];
        scnt_rd_reg <= scnt_mem[set_reg];
        sigc_rd_reg <= sigcnt_mem[sigc_ra];
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLR;
            clr_reg   <= '0;
            sel_reg   <= sdrrip_pkg::SEL_MID;
            rd_vld_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_CLR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg[AW-1:0] == '1) state_reg <= ST_IDLE;
                end
                ST_IDLE: if (s_valid) begin
                    set_reg  <= s_set_index[SW-1:0];
                    way_reg  <= s_way[WW-1:0];
                    sig_reg  <= s_pc[7:2] ^ s_set_index[5:0];
                    addr_reg <= s_address;
                    hit_reg  <= s_hit;
                    cnt_reg  <= '0;
                    state_reg <= (s_kind == sdrrip_pkg::KIND_UPDATE) ? ST_URD : ST_QRD;
                end
                ST_QRD: begin
                    // hold first read; advance index each cycle through max pass
                    cnt_reg <= cnt_reg + 1'b1;
                    rd_vld_reg <= 1'b0;
                    state_reg <= ST_QMAX;
                end
                ST_QMAX: begin
                    if (cnt_reg == (WW+1)'(sdrrip_pkg::NUM_WAYS)) begin
                        cnt_reg <= '0;
                        rd_vld_reg <= 1'b0;
                        state_reg <= ST_QAGE;
                    end else cnt_reg <= cnt_reg + 1'b1;
                end
                ST_QAGE: begin
                    if (!rd_vld_reg) delta_reg <= sdrrip_pkg::AGE_MAX - max_age;
                    rd_vld_reg <= 1'b1;
                    if (cnt_reg == (WW+1)'(sdrrip_pkg::NUM_WAYS - 1)) state_reg <= ST_QEND;
                    else cnt_reg <= cnt_reg + 1'b1;
                end
                ST_QEND: begin
                    // last way is still in flight through the scanner: check it here
                    state_reg <= ST_OUT;
                    vic_out_reg <= found ? victim :
                        ((age_rd_reg + delta_reg == sdrrip_pkg::AGE_MAX) ? rd_idx_reg : '0);
                    age_out_reg <= 2'd0;
                    strm_reg <= 1'b0;
                end
                ST_URD: state_reg <= ST_UOLD;
                ST_UOLD: begin
                    // store the stride state; old signature counter is being read
                    strm_reg <= (scnt_upd >= 2'd2);
                    state_reg <= ST_UDEC;
                end
                // reward or decay the signature stored with the way
                ST_UDEC: state_reg <= ST_URDN;
                ST_URDN: state_reg <= ST_UNEW;
                ST_UNEW: begin
                    if (hit_reg) begin
                        age_out_reg <= 2'd0;
                        if (lk == sdrrip_pkg::LK_BRRIP && sigc_rd_reg >= sdrrip_pkg::CNT_HOT
                            && sel_reg > 10'd0) sel_reg <= sel_reg - 10'd1;
                    end else begin
                        if (strm_reg) age_out_reg <= 2'd2;
                        else if (sigc_rd_reg >= sdrrip_pkg::CNT_HOT) age_out_reg <= 2'd0;
                        else age_out_reg <= brrip_sel ? 2'd2 : 2'd1;
                        if (lk == sdrrip_pkg::LK_SRRIP && sigc_rd_reg < sdrrip_pkg::CNT_HOT
                            && !strm_reg && sel_reg < sdrrip_pkg::SEL_MAX)
                            sel_reg <= sel_reg + 10'd1;
                    end
                    vic_out_reg <= '0;
                    state_reg <= ST_UWR;
                end
                ST_UWR: state_reg <= ST_OUT;
                ST_OUT: if (m_ready) state_reg <= ST_IDLE;
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    property p_no_in_when_busy;
        @(posedge aclk) disable iff (!aresetn) m_valid |-> !s_ready;
    endproperty
    a_no_in_when_busy: assert property (p_no_in_when_busy) else $error("ready while result held");

    property p_query_zero_age;
        @(posedge aclk) disable iff (!aresetn)
            (state_reg == ST_QEND) |=> (m_inserted_age == 2'd0 && !m_streaming);
    endproperty
    a_query_zero_age: assert property (p_query_zero_age) else $error("query result not clean");

    property p_out_holds;
        @(posedge aclk) disable iff (!aresetn)
            (m_valid && !m_ready) |=> (m_valid && $stable(m_victim_way));
    endproperty
    a_out_holds: assert property (p_out_holds) else $error("result changed while stalled");
endmodule

[hdl/sdrrip_age_scan.sv]
// Serial way scanner: finds the oldest age, then the lowest way at age 3.
// Depends on sdrrip_pkg.
module sdrrip_age_scan (
    input  logic                              aclk,
    input  logic                              start,
    input  logic                              pass2,
    input  logic [sdrrip_pkg::WAY_W-1:0]      idx,
    input  logic [1:0]                        age,
    output logic [1:0]                        max_age,
    output logic [sdrrip_pkg::WAY_W-1:0]      victim,
    output logic                              found
);
    logic [1:0] max_reg;
    logic [sdrrip_pkg::WAY_W-1:0] vic_reg;
    logic fnd_reg;

    always_ff @(posedge aclk) begin
        if (start) begin
            max_reg <= 2'd0;
            fnd_reg <= 1'b0;
            vic_reg <= '0;
        end else if (!pass2) begin
            if (age > max_reg) max_reg <= age;
        end else if (!fnd_reg && age == sdrrip_pkg::AGE_MAX) begin
            fnd_reg <= 1'b1;
            vic_reg <= idx;
        end
    end
    assign max_age = max_reg;
    assign victim  = vic_reg;
    assign found   = fnd_reg;
endmodule
